// ===== sv/tmeb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and the blend rule for the tile map edge-blend renderer.
// No dependencies.
package tmeb_pkg;

	localparam int OP_W    = 2;
	localparam int IDX_W   = 14;
	localparam int VAL_W   = 8;
	localparam int COORD_W = 6;
	localparam int LEVEL_W = 2;

	// one lookup lane per neighbor: 3 rows x 3 columns
	localparam int NLANE = 9;

	localparam int SCREEN_WIDTH_DEF  = 64;
	localparam int SCREEN_HEIGHT_DEF = 48;
	localparam int TILE_SIZE_DEF     = 8;
	localparam int TILE_COUNT_DEF    = 256;

	localparam logic [OP_W-1:0] OP_MAP_WR   = 2'd0;
	localparam logic [OP_W-1:0] OP_GLYPH_WR = 2'd1;
	localparam logic [OP_W-1:0] OP_RENDER   = 2'd2;

	localparam logic [LEVEL_W-1:0] LVL_BLACK = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_GREY  = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_WHITE = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [IDX_W-1:0]   store_index;
		logic [VAL_W-1:0]   write_value;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] pixel_level;
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
	} out_item_t;

	// store writes broadcast to every lane copy
	typedef struct packed {
		logic               map_we;
		logic [IDX_W-1:0]   map_idx;
		logic [VAL_W-1:0]   map_val;
		logic               glyph_we;
		logic [IDX_W-1:0]   glyph_idx;
		logic [LEVEL_W-1:0] glyph_lvl;
	} wr_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
	} cmd_t;

	typedef struct packed {
		logic               xedge;
		logic               yedge;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} rnd_t;

	function automatic logic [LEVEL_W-1:0] blend(input logic [LEVEL_W-1:0] prv,
			input logic [LEVEL_W-1:0] ctr, input logic [LEVEL_W-1:0] nxt);
		logic [LEVEL_W:0]   s;
		logic [LEVEL_W-1:0] r;
		s = {1'b0, prv} + {1'b0, nxt};
		case (ctr)
			LVL_BLACK: begin
				r = (s >= (LEVEL_W+1)'(2)) ? LVL_GREY : LVL_BLACK;
			end
			LVL_GREY: begin
				if (s == '0)
					r = LVL_BLACK;
				else if (s >= (LEVEL_W+1)'(3))
					r = LVL_WHITE;
				else
					r = LVL_GREY;
			end
			default: begin
				r = (s == '0) ? LVL_GREY : LVL_WHITE;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== sv/tile_map_edge_blend_renderer_core.sv =====
`timescale 1ns / 1ps
// Tile map edge-blend renderer in seven register stages; a render item shows on res once it
// has passed all seven and can be taken from then on.
// Throughput: one item per cycle while not stalled; only render items produce a result item.
// Nine lanes, each with its own map and glyph copy, fetch the 3x3 neighborhood at once.
// A held result stalls the whole pipe; nothing enters until it is taken.
// Reset clears the valid bits only; map and glyph contents are undefined until written.
module tile_map_edge_blend_renderer_core #(
	parameter int SCREEN_WIDTH  = tmeb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = tmeb_pkg::SCREEN_HEIGHT_DEF,
	parameter int TILE_SIZE     = tmeb_pkg::TILE_SIZE_DEF,
	parameter int TILE_COUNT    = tmeb_pkg::TILE_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  tmeb_pkg::in_item_t   req_item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output tmeb_pkg::out_item_t  res_item
);

	localparam int TILES_ACROSS = (SCREEN_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
	localparam int TILES_DOWN   = (SCREEN_HEIGHT + TILE_SIZE - 1) / TILE_SIZE;
	localparam int MAP_DEPTH    = TILES_ACROSS * TILES_DOWN;
	localparam int MAP_AW       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int GLYPH_DEPTH  = TILE_COUNT * TILE_SIZE * TILE_SIZE;
	localparam int GLYPH_AW     = $clog2(GLYPH_DEPTH);
	localparam int OFF_W        = $clog2(TILE_SIZE * TILE_SIZE);
	localparam int NLANE        = tmeb_pkg::NLANE;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	tmeb_pkg::cmd_t cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	tmeb_pkg::rnd_t rnd_s2, rnd_s3, rnd_s4, rnd_s5, rnd_s6, rnd_s7;
	tmeb_pkg::wr_cmd_t wr;

	logic [MAP_AW-1:0]            map_addr_s2 [NLANE];
	logic [OFF_W-1:0]             off_s2 [NLANE];
	logic [tmeb_pkg::LEVEL_W-1:0] lvl_s5 [NLANE];
	logic [tmeb_pkg::LEVEL_W-1:0] lvl_s7;

	assign en        = !vld_s7 || res_ready;
	assign req_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			// write items are finished once the glyph stage is passed
			vld_s5 <= vld_s4 && (cmd_s4.op == tmeb_pkg::OP_RENDER);
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1.op  <= req_item.operation;
			cmd_s1.idx <= req_item.store_index;
			cmd_s1.val <= req_item.write_value;
			cmd_s2     <= cmd_s1;
			cmd_s3     <= cmd_s2;
			cmd_s4     <= cmd_s3;
			rnd_s3     <= rnd_s2;
			rnd_s4     <= rnd_s3;
			rnd_s5     <= rnd_s4;
			rnd_s6     <= rnd_s5;
			rnd_s7     <= rnd_s6;
		end
	end

	// map writes land with the map read of stage 2, glyph writes with the
	// glyph read of stage 4, so every item sees the stores in arrival order
	always_comb begin
		wr.map_we    = vld_s2 && (cmd_s2.op == tmeb_pkg::OP_MAP_WR)
			&& (int'(cmd_s2.idx) < MAP_DEPTH);
		wr.map_idx   = cmd_s2.idx;
		wr.map_val   = cmd_s2.val;
		wr.glyph_we  = vld_s4 && (cmd_s4.op == tmeb_pkg::OP_GLYPH_WR)
			&& (int'(cmd_s4.idx) < GLYPH_DEPTH);
		wr.glyph_idx = cmd_s4.idx;
		wr.glyph_lvl = (cmd_s4.val > tmeb_pkg::VAL_W'(tmeb_pkg::LVL_GREY))
			? tmeb_pkg::LVL_WHITE : cmd_s4.val[tmeb_pkg::LEVEL_W-1:0];
	end

	tmeb_addr #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.TILE_SIZE     (TILE_SIZE),
		.MAP_AW        (MAP_AW),
		.OFF_W         (OFF_W)
	) u_addr (
		.clk         (clk),
		.en          (en),
		.item        (req_item),
		.map_addr_s2 (map_addr_s2),
		.off_s2      (off_s2),
		.rnd_s2      (rnd_s2)
	);

	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		tmeb_lane #(
			.TILE_SIZE   (TILE_SIZE),
			.TILE_COUNT  (TILE_COUNT),
			.MAP_DEPTH   (MAP_DEPTH),
			.MAP_AW      (MAP_AW),
			.GLYPH_DEPTH (GLYPH_DEPTH),
			.GLYPH_AW    (GLYPH_AW),
			.OFF_W       (OFF_W)
		) u_lane (
			.clk         (clk),
			.en          (en),
			.wr          (wr),
			.map_addr_s2 (map_addr_s2[l]),
			.off_s2      (off_s2[l]),
			.lvl_s5      (lvl_s5[l])
		);
	end

	tmeb_blend u_blend (
		.clk      (clk),
		.en       (en),
		.lvl_s5   (lvl_s5),
		.xedge_s5 (rnd_s5.xedge),
		.yedge_s5 (rnd_s5.yedge),
		.lvl_s7   (lvl_s7)
	);

	assign res_valid            = vld_s7;
	assign res_item.pixel_level = lvl_s7;
	assign res_item.out_x       = rnd_s7.x;
	assign res_item.out_y       = rnd_s7.y;

endmodule

// ===== sv/tmeb_addr.sv =====
`timescale 1ns / 1ps
// Address stages: coordinate clamp, mirrored neighbors, then map index and
// in-glyph offset for all nine lanes plus edge flags. Uses tmeb_pkg.
module tmeb_addr #(
	parameter int SCREEN_WIDTH  = tmeb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = tmeb_pkg::SCREEN_HEIGHT_DEF,
	parameter int TILE_SIZE     = tmeb_pkg::TILE_SIZE_DEF,
	parameter int MAP_AW        = 3,
	parameter int OFF_W         = 6
) (
	input  logic                 clk,
	input  logic                 en,
	input  tmeb_pkg::in_item_t   item,
	output logic [MAP_AW-1:0]    map_addr_s2 [tmeb_pkg::NLANE],
	output logic [OFF_W-1:0]     off_s2 [tmeb_pkg::NLANE],
	output tmeb_pkg::rnd_t       rnd_s2
);

	// one extra bit: the right/lower neighbor of the last field value
	localparam int CW           = tmeb_pkg::COORD_W + 1;
	localparam int XW           = tmeb_pkg::COORD_W;
	localparam int TW           = $clog2(TILE_SIZE);
	localparam int TILES_ACROSS = (SCREEN_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
	localparam int NTBL         = 2 ** CW;

	logic [CW-1:0] tdiv_tbl [NTBL];
	logic [TW-1:0] tmod_tbl [NTBL];

	for (genvar v = 0; v < NTBL; v++) begin : g_tbl
		assign tdiv_tbl[v] = CW'(v / TILE_SIZE);
		assign tmod_tbl[v] = TW'(v % TILE_SIZE);
	end

	logic [CW-1:0] xc, yc, px, nx, py, ny;
	logic [CW-1:0] col_s1 [3];
	logic [CW-1:0] row_s1 [3];

	always_comb begin
		if (int'(item.pixel_x) > SCREEN_WIDTH - 1)
			xc = CW'(SCREEN_WIDTH - 1);
		else
			xc = CW'(item.pixel_x);
		if (int'(item.pixel_y) > SCREEN_HEIGHT - 1)
			yc = CW'(SCREEN_HEIGHT - 1);
		else
			yc = CW'(item.pixel_y);
		// mirror at the screen border
		px = (xc != '0) ? xc - 1'b1 : xc + 1'b1;
		nx = (int'(xc) < SCREEN_WIDTH - 1) ? xc + 1'b1 : xc - 1'b1;
		py = (yc != '0) ? yc - 1'b1 : yc + 1'b1;
		ny = (int'(yc) < SCREEN_HEIGHT - 1) ? yc + 1'b1 : yc - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1[0] <= px;
			col_s1[1] <= xc;
			col_s1[2] <= nx;
			row_s1[0] <= py;
			row_s1[1] <= yc;
			row_s1[2] <= ny;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					map_addr_s2[j*3+i] <= MAP_AW'(int'(tdiv_tbl[row_s1[j]]) * TILES_ACROSS
						+ int'(tdiv_tbl[col_s1[i]]));
					off_s2[j*3+i] <= OFF_W'(int'(tmod_tbl[row_s1[j]]) * TILE_SIZE
						+ int'(tmod_tbl[col_s1[i]]));
				end
			end
			rnd_s2.xedge <= (tmod_tbl[col_s1[1]] == '0)
				|| (int'(tmod_tbl[col_s1[1]]) == TILE_SIZE - 1);
			rnd_s2.yedge <= (tmod_tbl[row_s1[1]] == '0)
				|| (int'(tmod_tbl[row_s1[1]]) == TILE_SIZE - 1);
			rnd_s2.x <= XW'(col_s1[1]);
			rnd_s2.y <= XW'(row_s1[1]);
		end
	end

endmodule

// ===== sv/tmeb_lane.sv =====
`timescale 1ns / 1ps
// One lookup lane: private copies of the tile map and glyph store, map read,
// glyph address, glyph read. Every lane sees every write. Uses tmeb_pkg.
module tmeb_lane #(
	parameter int TILE_SIZE   = tmeb_pkg::TILE_SIZE_DEF,
	parameter int TILE_COUNT  = tmeb_pkg::TILE_COUNT_DEF,
	parameter int MAP_DEPTH   = 48,
	parameter int MAP_AW      = 6,
	parameter int GLYPH_DEPTH = 16384,
	parameter int GLYPH_AW    = 14,
	parameter int OFF_W       = 6
) (
	input  logic                           clk,
	input  logic                           en,
	input  tmeb_pkg::wr_cmd_t              wr,
	input  logic [MAP_AW-1:0]              map_addr_s2,
	input  logic [OFF_W-1:0]               off_s2,
	output logic [tmeb_pkg::LEVEL_W-1:0]   lvl_s5
);

	logic [tmeb_pkg::VAL_W-1:0]   map_mem [MAP_DEPTH];
	logic [tmeb_pkg::LEVEL_W-1:0] glyph_mem [GLYPH_DEPTH];

	logic [tmeb_pkg::VAL_W-1:0]   tile_s3;
	logic [OFF_W-1:0]             off_s3;
	logic [GLYPH_AW-1:0]          gaddr_s4;
	logic                         tok_s4;
	logic [tmeb_pkg::LEVEL_W-1:0] glyph_s5;
	logic                         tok_s5;
	logic                         tok;

	assign tok = int'(tile_s3) < TILE_COUNT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (wr.map_we)
				map_mem[MAP_AW'(wr.map_idx)] <= wr.map_val;
			tile_s3 <= map_mem[map_addr_s2];
			off_s3  <= off_s2;
		end
	end

	// tile numbers past the glyph count read as black
	always_ff @(posedge clk) begin
		if (en) begin
			tok_s4   <= tok;
			gaddr_s4 <= tok ? GLYPH_AW'(int'(tile_s3) * (TILE_SIZE * TILE_SIZE) + int'(off_s3))
				: '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (wr.glyph_we)
				glyph_mem[GLYPH_AW'(wr.glyph_idx)] <= wr.glyph_lvl;
			glyph_s5 <= glyph_mem[gaddr_s4];
			tok_s5   <= tok_s4;
		end
	end

	assign lvl_s5 = tok_s5 ? glyph_s5 : tmeb_pkg::LVL_BLACK;

endmodule

// ===== sv/tmeb_blend.sv =====
`timescale 1ns / 1ps
// Blend stages: on a tile edge column, horizontal blend of the three rows;
// on an edge row, vertical blend of row results. Uses tmeb_pkg::blend.
module tmeb_blend (
	input  logic                           clk,
	input  logic                           en,
	input  logic [tmeb_pkg::LEVEL_W-1:0]   lvl_s5 [tmeb_pkg::NLANE],
	input  logic                           xedge_s5,
	input  logic                           yedge_s5,
	output logic [tmeb_pkg::LEVEL_W-1:0]   lvl_s7
);

	logic [tmeb_pkg::LEVEL_W-1:0] row_s6 [3];
	logic                         yedge_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				row_s6[j] <= xedge_s5
					? tmeb_pkg::blend(lvl_s5[j*3], lvl_s5[j*3+1], lvl_s5[j*3+2])
					: lvl_s5[j*3+1];
			end
			yedge_s6 <= yedge_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			lvl_s7 <= yedge_s6 ? tmeb_pkg::blend(row_s6[0], row_s6[1], row_s6[2]) : row_s6[1];
	end

endmodule

// ===== sv/tmeb_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the renderer core, attached by bind below.
// Uses tmeb_pkg types; sees the top-level ports only.
module tmeb_checker #(
	parameter int SCREEN_WIDTH  = tmeb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = tmeb_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  tmeb_pkg::in_item_t   req_item,
	input  logic                 res_valid,
	input  logic                 res_ready,
	input  tmeb_pkg::out_item_t  res_item
);

	// a waiting input item holds, unchanged
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req_item))
		else $error("input item changed while waiting");

	// a result that is not taken holds, unchanged
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result item changed while stalled");

	// a stalled result blocks new items
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !req_ready)
		else $error("input accepted while result stalled");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.pixel_level != 2'd3)
		else $error("rendered level out of range");

	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (int'(res_item.out_x) <= SCREEN_WIDTH - 1)
			&& (int'(res_item.out_y) <= SCREEN_HEIGHT - 1))
		else $error("rendered coordinate off screen");

endmodule

bind tile_map_edge_blend_renderer_core tmeb_checker #(
	.SCREEN_WIDTH  (SCREEN_WIDTH),
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tmeb_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for tile_map_edge_blend_renderer_core: map and glyph loads, renders, random idling.
// Depends on tmeb_pkg and the core. Renders are checked against a local edge-blend predictor.
module testbench;

	localparam int SCR_W        = tmeb_pkg::SCREEN_WIDTH_DEF;
	localparam int SCR_H        = tmeb_pkg::SCREEN_HEIGHT_DEF;
	localparam int TS           = tmeb_pkg::TILE_SIZE_DEF;
	localparam int NTILES       = tmeb_pkg::TILE_COUNT_DEF;
	localparam int TILES_ACROSS = (SCR_W + TS - 1) / TS;
	localparam int TILES_DOWN   = (SCR_H + TS - 1) / TS;
	localparam int MAP_DEPTH    = TILES_ACROSS * TILES_DOWN;
	localparam int GLYPH_DEPTH  = NTILES * TS * TS;
	localparam int RANDOM_ITEMS = 700;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 16;
	localparam int MAX_FILLS    = 8;
	localparam logic [tmeb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	tmeb_pkg::in_item_t req_item = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	tmeb_pkg::out_item_t res_item;

	tile_map_edge_blend_renderer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	always #1 clk = ~clk;

	// items waiting to be sent, and renders waiting for their pixel
	tmeb_pkg::in_item_t  item_queue[$];
	tmeb_pkg::out_item_t pixel_results[$];

	// predictor copy of the stores
	logic [tmeb_pkg::VAL_W-1:0]   map_mem [MAP_DEPTH];
	logic [tmeb_pkg::LEVEL_W-1:0] glyph_mem [GLYPH_DEPTH];

	// stimulus-side bookkeeping: which glyph pixels are loaded, which tiles are complete
	bit glyph_written [GLYPH_DEPTH];
	int tile_fill [NTILES];
	bit tile_ready [NTILES];
	int ready_tiles[$];

	int mismatches = 0;
	int quiet_cycles = 0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_span = 0;
	int stall_mode = 0;
	tmeb_pkg::out_item_t want;

	task automatic queue_item(logic [tmeb_pkg::OP_W-1:0] op, logic [31:0] idx,
			logic [31:0] val, logic [31:0] x, logic [31:0] y);
		tmeb_pkg::in_item_t it;
		it.operation   = op;
		it.store_index = idx[tmeb_pkg::IDX_W-1:0];
		it.write_value = val[tmeb_pkg::VAL_W-1:0];
		it.pixel_x     = x[tmeb_pkg::COORD_W-1:0];
		it.pixel_y     = y[tmeb_pkg::COORD_W-1:0];
		item_queue.push_back(it);
	endtask

	task automatic queue_glyph_write(int idx, logic [31:0] val);
		int t;
		queue_item(tmeb_pkg::OP_GLYPH_WR, idx, val, $urandom, $urandom);
		if (!glyph_written[idx]) begin
			glyph_written[idx] = 1'b1;
			t = idx / (TS * TS);
			tile_fill[t]++;
			if (tile_fill[t] == TS * TS) begin
				tile_ready[t] = 1'b1;
				ready_tiles.push_back(t);
			end
		end
	endtask

	task automatic queue_render(int x, int y);
		queue_item(tmeb_pkg::OP_RENDER, $urandom, $urandom, x, y);
	endtask

	// mostly legal levels, now and then a raw byte to hit saturation
	function automatic logic [31:0] glyph_value();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2);
	endfunction

	task automatic fill_tile(int t);
		for (int p = 0; p < TS * TS; p++)
			queue_glyph_write(t * TS * TS + p, glyph_value());
	endtask

	function automatic int any_ready_tile();
		return ready_tiles[$urandom_range(0, ready_tiles.size() - 1)];
	endfunction

	function automatic logic [tmeb_pkg::LEVEL_W-1:0] mix(logic [tmeb_pkg::LEVEL_W-1:0] left,
			logic [tmeb_pkg::LEVEL_W-1:0] mid, logic [tmeb_pkg::LEVEL_W-1:0] right);
		int unsigned total;
		total = left + right;
		if (mid == tmeb_pkg::LVL_BLACK)
			return (total >= 2) ? tmeb_pkg::LVL_GREY : tmeb_pkg::LVL_BLACK;
		if (mid == tmeb_pkg::LVL_GREY)
			return (total == 0) ? tmeb_pkg::LVL_BLACK
				: ((total >= 3) ? tmeb_pkg::LVL_WHITE : tmeb_pkg::LVL_GREY);
		return (total == 0) ? tmeb_pkg::LVL_GREY : tmeb_pkg::LVL_WHITE;
	endfunction

	function automatic logic [tmeb_pkg::LEVEL_W-1:0] lookup(int x, int y);
		int m;
		int g;
		m = (y / TS) * TILES_ACROSS + x / TS;
		// 8-bit tile numbers never reach the tile count, so every entry maps to a glyph
		g = int'(map_mem[m]) * TS * TS + (y % TS) * TS + (x % TS);
		return glyph_mem[g];
	endfunction

	function automatic logic [tmeb_pkg::LEVEL_W-1:0] row_blend(int x, int y);
		logic [tmeb_pkg::LEVEL_W-1:0] c;
		int l;
		int r;
		c = lookup(x, y);
		if (x % TS == 0 || x % TS == TS - 1) begin
			l = (x > 0) ? x - 1 : x + 1;
			r = (x < SCR_W - 1) ? x + 1 : x - 1;
			c = mix(lookup(l, y), c, lookup(r, y));
		end
		return c;
	endfunction

	task automatic absorb_item(tmeb_pkg::in_item_t it);
		tmeb_pkg::out_item_t px;
		int x;
		int y;
		int up;
		int dn;
		logic [tmeb_pkg::LEVEL_W-1:0] c;
		case (it.operation)
			tmeb_pkg::OP_MAP_WR: begin
				if (it.store_index < MAP_DEPTH)
					map_mem[it.store_index] = it.write_value;
			end
			tmeb_pkg::OP_GLYPH_WR: begin
				if (it.store_index < GLYPH_DEPTH)
					glyph_mem[it.store_index] = (it.write_value >= 2) ? tmeb_pkg::LVL_WHITE
						: it.write_value[tmeb_pkg::LEVEL_W-1:0];
			end
			tmeb_pkg::OP_RENDER: begin
				x = (it.pixel_x > SCR_W - 1) ? SCR_W - 1 : it.pixel_x;
				y = (it.pixel_y > SCR_H - 1) ? SCR_H - 1 : it.pixel_y;
				c = row_blend(x, y);
				if (y % TS == 0 || y % TS == TS - 1) begin
					up = (y > 0) ? y - 1 : y + 1;
					dn = (y < SCR_H - 1) ? y + 1 : y - 1;
					c = mix(row_blend(x, up), c, row_blend(x, dn));
				end
				px.pixel_level = c;
				px.out_x = x[tmeb_pkg::COORD_W-1:0];
				px.out_y = y[tmeb_pkg::COORD_W-1:0];
				pixel_results.push_back(px);
			end
			default: begin
			end
		endcase
	endtask

	task automatic report(string field, int expected, int actual);
		mismatches++;
		$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, expected, actual);
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (item_queue.size() > 0) begin
				req_item <= item_queue.pop_front();
				req_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: spans of always ready, mostly ready, mostly stalled, fully stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (stall_span == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_span = $urandom_range(4, 24);
			end else begin
				stall_span--;
			end
			case (stall_mode)
				0: res_ready <= 1'b1;
				1: res_ready <= ($urandom_range(0, 3) != 0);
				2: res_ready <= ($urandom_range(0, 3) == 0);
				default: res_ready <= 1'b0;
			endcase
		end
	end

	// check results first, then fold the accepted item into the predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (pixel_results.size() == 0) begin
					mismatches++;
					$display("%0t: pixel with no render pending: expected none, got level %0d x %0d y %0d",
						$time, res_item.pixel_level, res_item.out_x, res_item.out_y);
				end else begin
					want = pixel_results.pop_front();
					if (res_item.pixel_level !== want.pixel_level)
						report("pixel_level", want.pixel_level, res_item.pixel_level);
					if (res_item.out_x !== want.out_x)
						report("out_x", want.out_x, res_item.out_x);
					if (res_item.out_y !== want.out_y)
						report("out_y", want.out_y, res_item.out_y);
				end
			end
			if (req_valid && req_ready)
				absorb_item(req_item);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (res_valid && res_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int pick;
		int counted;
		int fills;
		int t;
		counted = 0;
		fills = 0;

		// load four complete tiles whose numbers toggle every bit, then the whole map
		fill_tile(0);
		fill_tile(255);
		fill_tile(85);
		fill_tile(170);
		for (int m = 0; m < MAP_DEPTH; m++)
			queue_item(tmeb_pkg::OP_MAP_WR, m, any_ready_tile(), $urandom, $urandom);

		// directed: borders, clamping, tile edges, saturation, ignored items
		queue_item(tmeb_pkg::OP_MAP_WR, 0, 255, $urandom, $urandom);
		queue_glyph_write(255 * TS * TS, 255);
		queue_glyph_write(255 * TS * TS + 1, 3);
		queue_render(0, 0);
		queue_render(SCR_W - 1, SCR_H - 1);
		queue_render(SCR_W - 1, 63);
		queue_render(0, 63);
		queue_render(TS - 1, TS);
		queue_render(TS, TS - 1);
		queue_render(3, 3);
		queue_render(SCR_W - 2, SCR_H - 2);
		queue_render(1, 0);
		queue_render(0, 20);
		queue_item(OP_UNUSED, 16383, 255, 63, 63);
		queue_item(tmeb_pkg::OP_MAP_WR, MAP_DEPTH, 255, $urandom, $urandom);
		queue_item(tmeb_pkg::OP_MAP_WR, 16383, 0, $urandom, $urandom);
		queue_render(40, 24);
		queue_glyph_write(TS * TS - 1, 0);
		queue_glyph_write(170 * TS * TS, 1);
		queue_render(56, 40);
		queue_render(31, 47);

		while (counted < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 199);
			if (pick < 100) begin
				queue_render($urandom_range(0, 63), $urandom_range(0, 63));
				counted++;
			end else if (pick < 130) begin
				queue_glyph_write(any_ready_tile() * TS * TS + $urandom_range(0, TS * TS - 1),
					glyph_value());
				counted++;
			end else if (pick < 146) begin
				queue_item(tmeb_pkg::OP_MAP_WR, $urandom_range(0, MAP_DEPTH - 1),
					any_ready_tile(), $urandom, $urandom);
				counted++;
			end else if (pick < 166) begin
				queue_glyph_write($urandom_range(0, GLYPH_DEPTH - 1), $urandom_range(0, 255));
				counted++;
			end else if (pick < 168 && fills < MAX_FILLS) begin
				// load a fresh tile completely, then show it somewhere on screen
				t = $urandom_range(0, NTILES - 1);
				while (tile_ready[t])
					t = $urandom_range(0, NTILES - 1);
				fill_tile(t);
				queue_item(tmeb_pkg::OP_MAP_WR, $urandom_range(0, MAP_DEPTH - 1), t,
					$urandom, $urandom);
				fills++;
				counted += TS * TS + 1;
			end else if (pick < 184) begin
				queue_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
			end else begin
				queue_item(tmeb_pkg::OP_MAP_WR, $urandom_range(MAP_DEPTH, 16383), $urandom,
					$urandom, $urandom);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (item_queue.size() != 0 || req_valid)
			@(posedge clk);
		while (pixel_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
